[rtl/brtc_pkg.sv]
// Shared types, constants and helpers for the BCD clock/calendar block.
package brtc_pkg;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam int YEAR_BASE_W     = 14;
    localparam logic [YEAR_BASE_W-1:0] YEAR_BASE_RESET = 14'd2000;

    // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for y < 43690
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // floor(v / 10) == (v * DIV10_MUL) >> DIV10_SHIFT for v < 1024
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef logic [4:0] month_len_t;

    localparam month_len_t MONTH_DAYS [12] = '{
        5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic       kind;
        logic [6:0] load_sec;
        logic [6:0] load_min;
        logic [5:0] load_hour;
        logic [2:0] load_weekday;
        logic [5:0] load_date;
        logic [4:0] load_month;
        logic [7:0] load_year;
    } item_t;

    typedef struct packed {
        logic [6:0] sec_bcd;
        logic [6:0] min_bcd;
        logic [5:0] hour_bcd;
        logic [2:0] weekday;
        logic [5:0] date_bcd;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
        logic       day_rolled;
    } result_t;

    // Binary 0..99 to two BCD digits
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'(DIV10_MUL);
        tens = prod[DIV10_SHIFT+3:DIV10_SHIFT];
        ones = v - (7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    // Two BCD-ish digits to binary, tens digit of up to four bits
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        return 8'(v[7:4] * 8'd10) + 8'(v[3:0]);
    endfunction

endpackage

[rtl/bcd_rtc_calendar_tick.sv]
// BCD real-time clock and calendar, top level.
//
// Item channel (item_valid / item_stall / item): each transfer is a
// one-second tick or a load of a full time. Result channel
// (result_valid / result_stall / result): one result per item with the
// time after that item and a midnight-crossing flag.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes year_base,
// the offset added to the two-digit year for the leap-year test; it is
// always ready.
// The item sits in the input register and goes through the carry logic
// into the result register when the result side can take it. Throughput
// is one item per cycle while the result is not stalled; the carry chain
// from seconds through the leap-year divisibility test is combinational.
// When the receiver stalls the result register holds, the input register
// still takes one item, and item_stall rises only when both are full.
// Reset sets 00:00:00, weekday 1, date 01-01-00 and year_base 2000, and
// empties both registers.
module bcd_rtc_calendar_tick (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  brtc_pkg::item_t item,
    output logic            result_valid,
    input  logic            result_stall,
    output brtc_pkg::result_t result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [13:0]     cfg_data
);
    import brtc_pkg::*;

    logic [YEAR_BASE_W-1:0] year_base_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;

    logic [6:0] seconds_reg, seconds_next;
    logic [6:0] minutes_reg, minutes_next;
    logic [5:0] hours_reg, hours_next;
    logic [2:0] weekday_reg, weekday_next;
    logic [5:0] date_reg, date_next;
    logic [4:0] month_reg, month_next;
    logic [7:0] year_reg, year_next;
    logic       rolled;

    logic advance;
    logic accept;

    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Carry logic
    logic        sec_carry, min_carry;
    logic [7:0]  hr_bin, date_bin, mon_bin, yr_bin;
    logic [14:0] full_year;
    logic [27:0] div_prod;
    logic [7:0]  cent_q;
    logic        div100, div400, leap;
    logic [4:0]  month_len;

    always_comb
    begin
        seconds_next = seconds_reg;
        minutes_next = minutes_reg;
        hours_next   = hours_reg;
        weekday_next = weekday_reg;
        date_next    = date_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        rolled       = 1'b0;
        sec_carry    = 1'b0;
        min_carry    = 1'b0;

        hr_bin   = bcd_to_bin({2'b00, hours_reg}) + 8'd1;
        date_bin = bcd_to_bin({2'b00, date_reg}) + 8'd1;
        mon_bin  = bcd_to_bin({3'b000, month_reg});
        yr_bin   = bcd_to_bin(year_reg);

        full_year = {1'b0, year_base_reg} + 15'(yr_bin);
        div_prod  = 28'(full_year) * 28'(DIV100_MUL);
        cent_q    = div_prod[DIV100_SHIFT+7:DIV100_SHIFT];
        div100    = (15'(cent_q) * 15'd100) == full_year;
        div400    = div100 && (cent_q[1:0] == 2'b00);
        leap      = ((full_year[1:0] == 2'b00) && !div100) || div400;

        month_len = 5'd31;
        if ((mon_bin >= 8'd1) && (mon_bin <= 8'd12))
        begin
            month_len = MONTH_DAYS[4'(mon_bin - 8'd1)];
            if ((mon_bin == 8'd2) && !leap)
                month_len = 5'd28;
        end

        if (item_reg.kind == KIND_LOAD)
        begin
            seconds_next = item_reg.load_sec;
            minutes_next = item_reg.load_min;
            hours_next   = item_reg.load_hour;
            weekday_next = item_reg.load_weekday;
            date_next    = item_reg.load_date;
            month_next   = item_reg.load_month;
            year_next    = item_reg.load_year;
        end
        else
        begin
            // digit-wise count; ones of 9 or more carries
            if (seconds_reg[3:0] >= 4'd9)
            begin
                if (seconds_reg[6:4] >= 3'd5)
                begin
                    seconds_next = 7'h00;
                    sec_carry    = 1'b1;
                end
                else
                    seconds_next = {seconds_reg[6:4] + 3'd1, 4'd0};
            end
            else
                seconds_next = {seconds_reg[6:4], seconds_reg[3:0] + 4'd1};

            if (sec_carry)
            begin
                if (minutes_reg[3:0] >= 4'd9)
                begin
                    if (minutes_reg[6:4] >= 3'd5)
                    begin
                        minutes_next = 7'h00;
                        min_carry    = 1'b1;
                    end
                    else
                        minutes_next = {minutes_reg[6:4] + 3'd1, 4'd0};
                end
                else
                    minutes_next = {minutes_reg[6:4], minutes_reg[3:0] + 4'd1};
            end

            if (min_carry)
            begin
                if (hr_bin < 8'd24)
                    hours_next = 6'(bin_to_bcd(hr_bin[6:0]));
                else
                begin
                    hours_next = 6'h00;
                    rolled     = 1'b1;
                end
            end

            if (rolled)
            begin
                if ((weekday_reg == 3'd7) || (weekday_reg == 3'd0))
                    weekday_next = 3'd1;
                else
                    weekday_next = weekday_reg + 3'd1;

                if (date_bin <= 8'(month_len))
                    date_next = 6'(bin_to_bcd(date_bin[6:0]));
                else
                begin
                    date_next = 6'h01;
                    if (mon_bin >= 8'd12)
                    begin
                        month_next = 5'h01;
                        if (yr_bin >= 8'd99)
                            year_next = 8'h00;
                        else
                            year_next = bin_to_bcd(7'(yr_bin + 8'd1));
                    end
                    else
                        month_next = 5'(bin_to_bcd(7'(mon_bin + 8'd1)));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_base_reg    <= YEAR_BASE_RESET;
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            seconds_reg      <= 7'h00;
            minutes_reg      <= 7'h00;
            hours_reg        <= 6'h00;
            weekday_reg      <= 3'd1;
            date_reg         <= 6'h01;
            month_reg        <= 5'h01;
            year_reg         <= 8'h00;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                year_base_reg <= cfg_data;

            if (accept)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                seconds_reg      <= seconds_next;
                minutes_reg      <= minutes_next;
                hours_reg        <= hours_next;
                weekday_reg      <= weekday_next;
                date_reg         <= date_next;
                month_reg        <= month_next;
                year_reg         <= year_next;
            end
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (advance)
        begin
            result_reg.sec_bcd    <= seconds_next;
            result_reg.min_bcd    <= minutes_next;
            result_reg.hour_bcd   <= hours_next;
            result_reg.weekday    <= weekday_next;
            result_reg.date_bcd   <= date_next;
            result_reg.month_bcd  <= month_next;
            result_reg.year_bcd   <= year_next;
            result_reg.day_rolled <= rolled;
        end
    end

endmodule

[rtl/brtc_checker.sv]
// Port-level checks for the BCD clock/calendar block, bound to the top level.
module brtc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input brtc_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input brtc_pkg::result_t result,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [13:0]       cfg_data
);
    import brtc_pkg::*;

    // a held result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // the input side backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled without a stalled result");

    // a midnight crossing leaves the clock at 00:00:00 with a nonzero date
    a_midnight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.day_rolled |->
            (result.sec_bcd == 7'h00) && (result.min_bcd == 7'h00) &&
            (result.hour_bcd == 6'h00) && (result.date_bcd != 6'h00))
        else $error("day rollover with nonzero time");

    // a rollover leaves the weekday nonzero
    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.day_rolled |-> (result.weekday != 3'd0))
        else $error("rollover produced an invalid weekday");

endmodule

bind bcd_rtc_calendar_tick brtc_checker u_brtc_checker (.*);
